// ===== hdl/bline_pkg.sv =====
package bline_pkg;

  // default coordinate width (two's complement)
  localparam int unsigned COORD_BITS_DEF = 6;

  // surface size registers
  localparam int unsigned REG_W   = 6;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned APB_W   = 32;
  localparam int unsigned ADDR_W  = 3;

  localparam logic [REG_W-1:0] SURF_RESET = 6'd32;

  // register indexes (paddr[2])
  localparam logic REG_WIDTH_IDX  = 1'b0;
  localparam logic REG_HEIGHT_IDX = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch a new line command
    logic swap_axes;  // steepness test, swap x/y if steep
    logic order;      // order endpoints, load deltas and error term
    logic emit;       // load output register and advance one major step
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic at_end;     // current major coordinate is the final one
  } status_t;

endpackage

// ===== hdl/bresenham_line_raster.sv =====
// Bresenham line rasteriser. Each input transaction is one line command
// (start and end point as COORD_BITS-bit two's complement, plus a 32-bit
// packed colour); the block answers with one output transaction per step
// along the major axis, i.e. max(|dx|,|dy|)+1 pixels, ending with tlast.
// Steep lines are walked along y, and every line is walked towards the
// larger major coordinate, so a line may come out end-first. tuser marks a
// pixel as visible when 0 <= x < surface_width and 0 <= y < surface_height
// (APB registers at 0x0 and 0x4, reset 32; a size of 0 clips everything,
// clipped pixels are still sent). A command is accepted in the idle state
// and then set up in the swap and order states of the controller; after
// that the datapath issues one pixel per cycle while the consumer keeps
// tready high. The next command is taken as soon as the last pixel has
// been loaded into the output register.
module bresenham_line_raster #(
  parameter int unsigned COORD_BITS = bline_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // line command stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // start_x, start_y, end_x, end_y, line_color, zero pad
  input  logic [((4*COORD_BITS+bline_pkg::COLOR_W+7)/8)*8-1:0] s_axis_tdata,
  // pixel stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [((2*COORD_BITS+bline_pkg::COLOR_W+7)/8)*8-1:0] m_axis_tdata,
  // visible
  output logic                              m_axis_tuser,
  // last_pixel
  output logic                              m_axis_tlast,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bline_pkg::ADDR_W-1:0]      paddr,
  input  logic [bline_pkg::APB_W-1:0]       pwdata,
  output logic [bline_pkg::APB_W-1:0]       prdata,
  output logic                              pready
);

  localparam int unsigned CB      = COORD_BITS;
  localparam int unsigned CW      = bline_pkg::COLOR_W;
  localparam int unsigned RW      = bline_pkg::REG_W;

  // ---------------------------------------------------------------
  // Surface size registers
  // ---------------------------------------------------------------
  logic [RW-1:0] width_q, height_q;
  logic          reg_sel;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bline_pkg::SURF_RESET;
      height_q <= bline_pkg::SURF_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        bline_pkg::REG_WIDTH_IDX:  width_q  <= pwdata[RW-1:0];
        bline_pkg::REG_HEIGHT_IDX: height_q <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      bline_pkg::REG_WIDTH_IDX:  prdata = bline_pkg::APB_W'(width_q);
      bline_pkg::REG_HEIGHT_IDX: prdata = bline_pkg::APB_W'(height_q);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Controller and datapath
  // ---------------------------------------------------------------
  bline_pkg::cmd_t    cmd;
  bline_pkg::status_t status;

  logic signed [CB-1:0] pixel_x, pixel_y;
  logic [CW-1:0]        pixel_color;

  bline_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bline_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .start_x_i     ($signed(s_axis_tdata[CB-1:0])),
    .start_y_i     ($signed(s_axis_tdata[2*CB-1:CB])),
    .end_x_i       ($signed(s_axis_tdata[3*CB-1:2*CB])),
    .end_y_i       ($signed(s_axis_tdata[4*CB-1:3*CB])),
    .line_color_i  (s_axis_tdata[4*CB+CW-1:4*CB]),
    .surf_width_i  (width_q),
    .surf_height_i (height_q),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .visible_o     (m_axis_tuser),
    .pixel_color_o (pixel_color),
    .last_pixel_o  (m_axis_tlast)
  );

  // pad bits of the output word are constant zero
  always_comb begin
    m_axis_tdata                  = '0;
    m_axis_tdata[CB-1:0]          = pixel_x;
    m_axis_tdata[2*CB-1:CB]       = pixel_y;
    m_axis_tdata[2*CB+CW-1:2*CB]  = pixel_color;
  end

endmodule

// ===== hdl/bline_ctrl.sv =====
module bline_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bline_pkg::status_t status_i,
  output bline_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSwap  = 2'd1;
  localparam logic [1:0] StOrder = 2'd2;
  localparam logic [1:0] StRun   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;
  logic       emit;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_vld_q;

  // output register free or draining this cycle
  assign emit = (state_q == StRun) && (!out_vld_q || out_ready_i);

  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = in_valid_i && (state_q == StIdle);
    cmd_o.swap_axes = (state_q == StSwap);
    cmd_o.order     = (state_q == StOrder);
    cmd_o.emit      = emit;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StSwap;
      StSwap:  state_d = StOrder;
      StOrder: state_d = StRun;
      StRun:   if (emit && status_i.at_end) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ===== hdl/bline_dp.sv =====
module bline_dp #(
  parameter int unsigned COORD_BITS = bline_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  bline_pkg::cmd_t                     cmd_i,
  output bline_pkg::status_t                  status_o,
  input  logic signed [COORD_BITS-1:0]        start_x_i,
  input  logic signed [COORD_BITS-1:0]        start_y_i,
  input  logic signed [COORD_BITS-1:0]        end_x_i,
  input  logic signed [COORD_BITS-1:0]        end_y_i,
  input  logic [bline_pkg::COLOR_W-1:0]       line_color_i,
  input  logic [bline_pkg::REG_W-1:0]         surf_width_i,
  input  logic [bline_pkg::REG_W-1:0]         surf_height_i,
  output logic signed [COORD_BITS-1:0]        pixel_x_o,
  output logic signed [COORD_BITS-1:0]        pixel_y_o,
  output logic                                visible_o,
  output logic [bline_pkg::COLOR_W-1:0]       pixel_color_o,
  output logic                                last_pixel_o
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned DW    = CB + 1;           // signed difference
  localparam int unsigned ERR_W = CB + 2;           // error term, -dmin..dmaj
  localparam int unsigned CMP_W = bline_pkg::REG_W + 1;

  logic signed [CB-1:0] ax_q, ay_q, bx_q, by_q;
  logic [bline_pkg::COLOR_W-1:0] color_q;
  logic                 steep_q;

  logic signed [CB-1:0] major_q, end_q, minor_q;
  logic [CB-1:0]        dmaj_q, dmin_q;
  logic signed [ERR_W-1:0] err_q;
  logic                 step_up_q;

  logic signed [CB-1:0] px_q, py_q;
  logic                 vis_q, last_q;
  logic [bline_pkg::COLOR_W-1:0] pcol_q;

  // shared delta / magnitude logic, used by both setup steps
  logic signed [DW-1:0] dx, dy;
  logic [CB-1:0]        adx, ady;
  logic                 steep, swap_pts, step_up;

  assign dx  = DW'(bx_q) - DW'(ax_q);
  assign dy  = DW'(by_q) - DW'(ay_q);
  assign adx = dx[DW-1] ? CB'(-dx) : CB'(dx);
  assign ady = dy[DW-1] ? CB'(-dy) : CB'(dy);
  assign steep    = ady > adx;
  assign swap_pts = ax_q > bx_q;
  assign step_up  = swap_pts ? (by_q < ay_q) : (ay_q < by_q);

  // Bresenham step
  logic signed [ERR_W-1:0] err_sub, err_d;
  logic signed [CB-1:0]    minor_d;
  logic signed [CB-1:0]    cur_x, cur_y;
  logic                    cur_vis;

  assign err_sub = err_q - $signed({2'b00, dmin_q});

  always_comb begin
    err_d   = err_sub;
    minor_d = minor_q;
    if (err_sub[ERR_W-1]) begin
      err_d   = err_sub + $signed({2'b00, dmaj_q});
      minor_d = step_up_q ? (minor_q + CB'(1)) : (minor_q - CB'(1));
    end
  end

  assign cur_x = steep_q ? minor_q : major_q;
  assign cur_y = steep_q ? major_q : minor_q;
  assign cur_vis = !cur_x[CB-1] && !cur_y[CB-1] &&
                   (CMP_W'($unsigned(cur_x)) < CMP_W'(surf_width_i)) &&
                   (CMP_W'($unsigned(cur_y)) < CMP_W'(surf_height_i));

  assign status_o.at_end = (major_q == end_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ax_q    <= start_x_i;
      ay_q    <= start_y_i;
      bx_q    <= end_x_i;
      by_q    <= end_y_i;
      color_q <= line_color_i;
    end
    if (cmd_i.swap_axes) begin
      steep_q <= steep;
      if (steep) begin
        ax_q <= ay_q;
        ay_q <= ax_q;
        bx_q <= by_q;
        by_q <= bx_q;
      end
    end
    if (cmd_i.order) begin
      major_q   <= swap_pts ? bx_q : ax_q;
      end_q     <= swap_pts ? ax_q : bx_q;
      minor_q   <= swap_pts ? by_q : ay_q;
      step_up_q <= step_up;
      dmaj_q    <= adx;
      dmin_q    <= ady;
      err_q     <= ERR_W'(adx >> 1);
    end
    if (cmd_i.emit) begin
      px_q    <= cur_x;
      py_q    <= cur_y;
      vis_q   <= cur_vis;
      pcol_q  <= color_q;
      last_q  <= (major_q == end_q);
      major_q <= major_q + CB'(1);
      minor_q <= minor_d;
      err_q   <= err_d;
    end
  end

  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign visible_o     = vis_q;
  assign pixel_color_o = pcol_q;
  assign last_pixel_o  = last_q;

endmodule

// ===== hdl/bline_chk.sv =====
module bline_chk #(
  parameter int unsigned COORD_BITS = bline_pkg::COORD_BITS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((2*COORD_BITS+bline_pkg::COLOR_W+7)/8)*8-1:0] m_axis_tdata,
  input logic m_axis_tuser,
  input logic m_axis_tlast
);

  // pixel held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // a pending pixel that is not the last one means a line is in flight
  a_busy_mid_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("command accepted in the middle of a line");

  // a command occupies the block for the setup cycles
  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after a command");

  // a taken non-final pixel is followed straight away by the next one
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a line run");

endmodule

bind bresenham_line_raster bline_chk #(
  .COORD_BITS (COORD_BITS)
) u_bline_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
